FILE: rtl/stable_priority_queue_unit_defines.svh
// Assertion macros for the stable priority queue unit checker.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
// Types and codes shared by the stable priority queue unit.
// No dependencies.
package spq_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int COUNT_W = 6;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] ident;
        logic [4:0]  hr;
        logic [5:0]  mn;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry ent;
    } t_cmd;

endpackage

FILE: rtl/spq_if.sv
// Request and response channel interfaces (valid/ready beats).
// Depends on nothing.
interface spq_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  priority_req;
    logic [15:0] flight_number;
    logic [4:0]  dep_hour;
    logic [5:0]  dep_minute;

    modport source (output valid, op, priority_req, flight_number, dep_hour, dep_minute,
                    input ready);
    modport sink   (input valid, op, priority_req, flight_number, dep_hour, dep_minute,
                    output ready);
endinterface

interface spq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_priority;
    logic [15:0] out_flight_number;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  count;

    modport source (output valid, status, out_priority, out_flight_number, out_hour,
                    out_minute, count, input ready);
    modport sink   (input valid, status, out_priority, out_flight_number, out_hour,
                    out_minute, count, output ready);
endinterface

FILE: rtl/spq_cell.sv
// One slot of the sorted shift chain: holds an entry, shifts on insert/remove.
// Depends on spq_pkg.
module spq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic                 i_clk,
    input  spq_pkg::t_cmd        i_cmd,
    input  logic [CW-1:0]        i_count,
    input  spq_pkg::t_entry      i_left,
    input  logic                 i_left_gt,
    input  spq_pkg::t_entry      i_right,
    output spq_pkg::t_entry      o_data,
    output logic                 o_gt
);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    spq_pkg::t_entry r_data;
    logic            w_occ;
    logic            w_take;

    assign w_occ  = IDX_C < i_count;
    assign o_gt   = w_occ && (r_data.prio > i_cmd.ent.prio);
    assign w_take = o_gt || (IDX_C == i_count);
    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && w_take) begin
            r_data <= i_left_gt ? i_left : i_cmd.ent;
        end else if (i_cmd.rem) begin
            r_data <= i_right;
        end
    end
endmodule

FILE: rtl/stable_priority_queue_unit.sv
// Stable priority queue unit: top level with the cell chain and result register.
// Depends on spq_pkg, spq_if.sv and spq_cell.
// One beat per cycle if ready: every cell compares against the new priority and
// shifts in parallel, so an insert or remove completes in the accepting cycle
// and its result sits in the output register the next cycle. Equal priorities
// leave in arrival order. Insert on full returns status full, remove on empty
// returns status empty with zero payload; count is the entry count after the beat.
module stable_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    spq_req_if.sink i_req,
    spq_rsp_if.source o_rsp
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    spq_pkg::t_entry w_data [QUEUE_DEPTH];
    logic            w_gt   [QUEUE_DEPTH];
    spq_pkg::t_cmd   w_cmd;

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_valid;
    logic [1:0]      r_status;
    spq_pkg::t_entry r_ent;
    logic [spq_pkg::COUNT_W-1:0] r_cnt_out;
    logic [CW+spq_pkg::COUNT_W-1:0] w_cnt_ext;

    logic w_acc;
    logic w_full;
    logic w_empty;

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign w_acc   = i_req.valid && i_req.ready;
    assign w_full  = r_count == DEPTH_C;
    assign w_empty = r_count == '0;

    assign w_cmd.ins = w_acc && (i_req.op == spq_pkg::OP_INSERT) && !w_full;
    assign w_cmd.rem = w_acc && (i_req.op == spq_pkg::OP_REMOVE) && !w_empty;
    assign w_cmd.ent.prio  = i_req.priority_req;
    assign w_cmd.ent.ident = i_req.flight_number;
    assign w_cmd.ent.hr    = i_req.dep_hour;
    assign w_cmd.ent.mn    = i_req.dep_minute;

    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.rem) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_cnt_ext = {{spq_pkg::COUNT_W{1'b0}}, n_count};

    genvar g;
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;
        logic            w_left_gt;

        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_gt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_data[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end

        spq_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd),
            .i_count   (r_count),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .o_data    (w_data[g]),
            .o_gt      (w_gt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cnt_out <= w_cnt_ext[spq_pkg::COUNT_W-1:0];
            if (i_req.op == spq_pkg::OP_INSERT) begin
                r_status <= w_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
                r_ent    <= '0;
            end else if (w_empty) begin
                r_status <= spq_pkg::ST_EMPTY;
                r_ent    <= '0;
            end else begin
                r_status <= spq_pkg::ST_OK;
                r_ent    <= w_data[0];
            end
        end
    end

    assign o_rsp.valid             = r_valid;
    assign o_rsp.status            = r_status;
    assign o_rsp.out_priority      = r_ent.prio;
    assign o_rsp.out_flight_number = r_ent.ident;
    assign o_rsp.out_hour          = r_ent.hr;
    assign o_rsp.out_minute        = r_ent.mn;
    assign o_rsp.count             = r_cnt_out;
endmodule

FILE: rtl/spq_checker.sv
// Port-level checker for the stable priority queue unit, bound to the top level.
// Depends on spq_pkg and stable_priority_queue_unit_defines.svh.
`include "stable_priority_queue_unit_defines.svh"

module spq_checker #(
    parameter int QUEUE_DEPTH = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [7:0]  i_prio,
    input logic [15:0] i_ident,
    input logic [4:0]  i_hr,
    input logic [5:0]  i_mn,
    input logic [5:0]  i_count
);
    localparam logic [5:0] DEPTH_LO = 6'(QUEUE_DEPTH);

    `SPQ_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable({i_status, i_prio, i_ident, i_hr, i_mn, i_count}), "stalled result beat changed")
    `SPQ_ASSERT_NEXT(a_accept_result, i_in_valid && i_in_ready, i_out_valid, "accepted beat gave no result")
    `SPQ_ASSERT_NOW(a_full_count, i_out_valid && (i_status == spq_pkg::ST_FULL), (i_count == DEPTH_LO) && (i_prio == 8'd0), "full status with wrong count")
    `SPQ_ASSERT_NOW(a_empty_zero, i_out_valid && (i_status == spq_pkg::ST_EMPTY), (i_count == 6'd0) && (i_ident == 16'd0) && (i_prio == 8'd0), "empty status with data")
endmodule

bind stable_priority_queue_unit spq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_prio      (o_rsp.out_priority),
    .i_ident     (o_rsp.out_flight_number),
    .i_hr        (o_rsp.out_hour),
    .i_mn        (o_rsp.out_minute),
    .i_count     (o_rsp.count)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for stable_priority_queue_unit: random and directed insert/remove
// beats, checked against a sorted-queue predictor. Depends on spq_pkg and spq_if.sv.
module tb_top;
    localparam int QDEPTH      = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 500;

    typedef struct packed {
        logic            op;
        spq_pkg::t_entry ent;
    } t_flight_req;

    typedef struct packed {
        logic [1:0]      status;
        spq_pkg::t_entry ent;
        logic [5:0]      count;
    } t_flight_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    spq_req_if req_ch();
    spq_rsp_if rsp_ch();

    stable_priority_queue_unit #(.QUEUE_DEPTH(QDEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_flight_req     flight_reqs[$];
    t_flight_req     cur_req;
    spq_pkg::t_entry sorted_flights[$];
    t_flight_rsp     due_results[$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int gen_level = 0;
    int n_gen = 0;
    int n_errors = 0;
    int n_beats = 0;
    int n_results = 0;
    int n_inserts = 0;
    int n_popped = 0;
    int n_full = 0;
    int n_empty = 0;
    int stall_cycles = 0;

    // Sorted-queue predictor: stable insert behind equal priorities, pop from head.
    task automatic apply_to_queue(input t_flight_req rq);
        t_flight_rsp r;
        int pos;
        r = '0;
        if (rq.op == spq_pkg::OP_INSERT) begin
            if (sorted_flights.size() >= QDEPTH) begin
                r.status = spq_pkg::ST_FULL;
                n_full++;
            end else begin
                pos = sorted_flights.size();
                while (pos > 0 && sorted_flights[pos-1].prio > rq.ent.prio) pos--;
                sorted_flights.insert(pos, rq.ent);
                r.status = spq_pkg::ST_OK;
                n_inserts++;
            end
        end else if (sorted_flights.size() == 0) begin
            r.status = spq_pkg::ST_EMPTY;
            n_empty++;
        end else begin
            r.ent = sorted_flights.pop_front();
            r.status = spq_pkg::ST_OK;
            n_popped++;
        end
        r.count = 6'(sorted_flights.size());
        due_results.push_back(r);
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, fname, want, got);
            n_errors++;
        end
    endtask

    task automatic add_req(input logic op, input logic [7:0] prio, input logic [15:0] ident,
                           input logic [4:0] hr, input logic [5:0] mn);
        t_flight_req rq;
        rq.op = op;
        rq.ent.prio = prio;
        rq.ent.ident = ident;
        rq.ent.hr = hr;
        rq.ent.mn = mn;
        flight_reqs.push_back(rq);
        n_gen++;
        if (op == spq_pkg::OP_INSERT && gen_level < QDEPTH) gen_level++;
        if (op == spq_pkg::OP_REMOVE && gen_level > 0) gen_level--;
    endtask

    function automatic logic [7:0] pick_prio();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return 8'($urandom_range(7));
        if (sel < 8) return 8'($urandom_range(255));
        return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
    endfunction

    task automatic add_rand_insert();
        logic [4:0] hr;
        logic [5:0] mn;
        hr = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
        mn = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
        add_req(spq_pkg::OP_INSERT, pick_prio(), 16'($urandom_range(65535)), hr, mn);
    endtask

    task automatic add_rand_remove();
        add_req(spq_pkg::OP_REMOVE, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                5'($urandom_range(31)), 6'($urandom_range(63)));
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (flight_reqs.size() != 0 || req_ch.valid || due_results.size() != 0);
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                apply_to_queue(cur_req);
                n_beats++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (flight_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_req = flight_reqs.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.op            <= cur_req.op;
                    req_ch.priority_req  <= cur_req.ent.prio;
                    req_ch.flight_number <= cur_req.ent.ident;
                    req_ch.dep_hour      <= cur_req.ent.hr;
                    req_ch.dep_minute    <= cur_req.ent.mn;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor
    always @(posedge i_clk) begin : rsp_mon
        t_flight_rsp want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_results++;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result beat: expected none, actual status %0h",
                             $time, rsp_ch.status);
                    n_errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", 16'(want.status), 16'(rsp_ch.status));
                    check_field("out_priority", 16'(want.ent.prio), 16'(rsp_ch.out_priority));
                    check_field("out_flight_number", want.ent.ident, rsp_ch.out_flight_number);
                    check_field("out_hour", 16'(want.ent.hr), 16'(rsp_ch.out_hour));
                    check_field("out_minute", 16'(want.ent.mn), 16'(rsp_ch.out_minute));
                    check_field("count", 16'(want.count), 16'(rsp_ch.count));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("[stable_priority_queue_unit] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int ph_start;
        int kind;
        int n;
        req_ch.valid = 1'b0;
        req_ch.op = spq_pkg::OP_INSERT;
        req_ch.priority_req = '0;
        req_ch.flight_number = '0;
        req_ch.dep_hour = '0;
        req_ch.dep_minute = '0;
        rsp_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 47 : 0;
            snk_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 25 : 0;
            if (ph == 0) begin
                add_req(spq_pkg::OP_REMOVE, 8'hFF, 16'hFFFF, 5'd31, 6'd63);
                add_req(spq_pkg::OP_INSERT, 8'd255, 16'hFFFF, 5'd31, 6'd63);
                add_req(spq_pkg::OP_INSERT, 8'd0, 16'h0000, 5'd0, 6'd0);
                add_req(spq_pkg::OP_INSERT, 8'd5, 16'hAAAA, 5'd10, 6'd21);
                add_req(spq_pkg::OP_INSERT, 8'd5, 16'h5555, 5'd21, 6'd42);
                add_req(spq_pkg::OP_INSERT, 8'd5, 16'h1234, 5'd23, 6'd59);
                add_req(spq_pkg::OP_INSERT, 8'd255, 16'h8001, 5'd24, 6'd60);
                add_req(spq_pkg::OP_INSERT, 8'd4, 16'h7FFE, 5'd15, 6'd30);
                add_req(spq_pkg::OP_INSERT, 8'd170, 16'hC3C3, 5'd1, 6'd1);
                repeat (9) add_req(spq_pkg::OP_REMOVE, 8'h00, 16'h0000, 5'd0, 6'd0);
            end
            ph_start = n_gen;
            while (n_gen - ph_start < PHASE_ITEMS) begin
                kind = $urandom_range(9);
                if (kind < 3) begin
                    while (gen_level < QDEPTH) add_rand_insert();
                    n = $urandom_range(3, 1);
                    repeat (n) add_rand_insert();
                end else if (kind < 5) begin
                    while (gen_level > 0) add_rand_remove();
                    n = $urandom_range(2, 1);
                    repeat (n) add_rand_remove();
                end else if (kind < 9) begin
                    n = $urandom_range(40, 10);
                    repeat (n) begin
                        if ($urandom_range(99) < 55) add_rand_insert();
                        else add_rand_remove();
                    end
                end else begin
                    n = $urandom_range(15, 5);
                    repeat (n) begin
                        add_req(1'($urandom_range(1)), 8'($urandom_range(255)),
                                16'($urandom_range(65535)), 5'($urandom_range(31)),
                                6'($urandom_range(63)));
                    end
                end
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("Covered %0d request beats and %0d result beats over three handshake phases.",
                 n_beats, n_results);
        $display("Stored %0d, popped %0d, refused %0d on full, %0d removes on empty.",
                 n_inserts, n_popped, n_full, n_empty);
        if (n_errors == 0) begin
            $display("[stable_priority_queue_unit] OK");
        end else begin
            $display("[stable_priority_queue_unit] ERROR");
        end
        $finish;
    end
endmodule
